[hdl/bhr_pkg.sv]
// bhr_pkg: shared types, codes and constants of the box hessian response core
// used by bhr_ctrl, bhr_datapath and box_hessian_response_core
package bhr_pkg;

    localparam int DEF_MAX_ROWS = 512;
    localparam int DEF_MAX_COLS = 512;

    localparam int IDX_W = 3;
    localparam int CFG_W = 24;
    localparam int VAL_W = 27;
    localparam int N_READS = 32;

    localparam logic [IDX_W-1:0] CFG_FILTER_SIZE = 3'd0;
    localparam logic [IDX_W-1:0] CFG_SAMPLE_STEP = 3'd1;
    localparam logic [IDX_W-1:0] CFG_IMAGE_ROWS  = 3'd2;
    localparam logic [IDX_W-1:0] CFG_IMAGE_COLS  = 3'd3;
    localparam logic [IDX_W-1:0] CFG_INV_AREA    = 3'd4;

    localparam logic [7:0]  RST_FILTER_SIZE = 8'd9;
    localparam logic [4:0]  RST_SAMPLE_STEP = 5'd1;
    localparam logic [9:0]  RST_IMAGE_ROWS  = 10'd512;
    localparam logic [9:0]  RST_IMAGE_COLS  = 10'd512;
    localparam logic [23:0] RST_INV_AREA    = 24'd207126;

    localparam logic KIND_QUERY = 1'b1;

    localparam logic [16:0] COEF_081 = 17'd53084;
    localparam logic [8:0]  DIV3_MUL = 9'd171;

    typedef struct packed {
        logic        kind;
        logic [8:0]  row;
        logic [8:0]  col;
        logic [26:0] integral_value;
    } t_in_item;

    typedef struct packed {
        logic signed [39:0] response;
        logic               laplacian_sign;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SETUP,
        S_READ,
        S_DRAIN,
        S_N0,
        S_N1,
        S_N2,
        S_P,
        S_Q,
        S_QW,
        S_WL,
        S_WH,
        S_WW,
        S_WT,
        S_RESP,
        S_OUT
    } t_state;

    typedef enum logic [2:0] {
        OP_NXX,
        OP_NYY,
        OP_NXY,
        OP_P,
        OP_Q,
        OP_WL,
        OP_WH
    } t_op;

    typedef struct packed {
        logic       accept;
        logic       setup;
        logic       issue;
        logic [4:0] idx;
        logic       op_valid;
        t_op        op;
        logic       calc_wt;
        logic       calc_resp;
        logic       out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic pipe_busy;
        logic out_free;
    } t_dp_sts;

endpackage

[hdl/bhr_ram.sv]
// bhr_ram: generic simple dual port ram, one write and one registered read port
// no dependencies
module bhr_ram #(
    parameter int WIDTH = 27,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/bhr_ctrl.sv]
// bhr_ctrl: query sequencer state machine, drives datapath commands
// depends on bhr_pkg
module bhr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_kind,
    output logic              o_in_stall,
    output bhr_pkg::t_dp_cmd  o_cmd,
    input  bhr_pkg::t_dp_sts  i_sts
);
    import bhr_pkg::*;

    localparam logic [4:0] LAST_READ = 5'(N_READS - 1);

    t_state     r_state, n_state;
    logic [4:0] r_idx, n_idx;
    t_dp_cmd    cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        cmd     = '0;
        cmd.op  = OP_NXX;
        case (r_state)
            S_IDLE: begin
                cmd.accept = i_in_valid;
                if (i_in_valid && i_in_kind == KIND_QUERY) begin
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                cmd.setup = 1'b1;
                n_idx     = '0;
                n_state   = S_READ;
            end
            S_READ: begin
                cmd.issue = 1'b1;
                cmd.idx   = r_idx;
                n_idx     = r_idx + 5'd1;
                if (r_idx == LAST_READ) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_sts.pipe_busy) begin
                    n_state = S_N0;
                end
            end
            S_N0: begin
                cmd.op_valid = 1'b1;
                cmd.op       = OP_NXX;
                n_state      = S_N1;
            end
            S_N1: begin
                cmd.op_valid = 1'b1;
                cmd.op       = OP_NYY;
                n_state      = S_N2;
            end
            S_N2: begin
                cmd.op_valid = 1'b1;
                cmd.op       = OP_NXY;
                n_state      = S_P;
            end
            S_P: begin
                cmd.op_valid = 1'b1;
                cmd.op       = OP_P;
                n_state      = S_Q;
            end
            S_Q: begin
                cmd.op_valid = 1'b1;
                cmd.op       = OP_Q;
                n_state      = S_QW;
            end
            S_QW: begin
                n_state = S_WL;
            end
            S_WL: begin
                cmd.op_valid = 1'b1;
                cmd.op       = OP_WL;
                n_state      = S_WH;
            end
            S_WH: begin
                cmd.op_valid = 1'b1;
                cmd.op       = OP_WH;
                n_state      = S_WW;
            end
            S_WW: begin
                n_state = S_WT;
            end
            S_WT: begin
                cmd.calc_wt = 1'b1;
                n_state     = S_RESP;
            end
            S_RESP: begin
                cmd.calc_resp = 1'b1;
                n_state       = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_cmd      = cmd;
    assign o_in_stall = (r_state != S_IDLE);

`ifndef NO_ASSERTIONS
    a_read_to_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ && r_idx == LAST_READ) |=> (r_state == S_DRAIN))
        else $error("read phase did not end after last corner");
    a_query_setup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_in_kind == KIND_QUERY) |=> (r_state == S_SETUP))
        else $error("query transfer did not start setup");
    a_op_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.op_valid |-> !i_sts.pipe_busy)
        else $error("arithmetic started while box pipeline busy");
`endif

endmodule

[hdl/bhr_datapath.sv]
// bhr_datapath: config registers, integral store, corner pipeline, box sums,
// shared multiplier and output register; depends on bhr_pkg and bhr_ram
module bhr_datapath #(
    parameter int MAX_ROWS = bhr_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = bhr_pkg::DEF_MAX_COLS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bhr_pkg::t_in_item             i_in_data,
    input  bhr_pkg::t_dp_cmd              i_cmd,
    output bhr_pkg::t_dp_sts              o_sts,
    input  logic                          i_cfg_we,
    input  logic [bhr_pkg::IDX_W-1:0]     i_cfg_index,
    input  logic [bhr_pkg::CFG_W-1:0]     i_cfg_wdata,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output bhr_pkg::t_out_item            o_out_data
);
    import bhr_pkg::*;

    localparam int AWR   = $clog2(MAX_ROWS);
    localparam int AWC   = $clog2(MAX_COLS);
    localparam int AW    = AWR + AWC;
    localparam int DEPTH = 1 << AW;
    localparam int SW    = 17;
    localparam int BW    = 29;

    localparam logic signed [SW-1:0] ONE = SW'(1);

    // configuration
    logic [7:0]  r_fsize;
    logic [4:0]  r_step;
    logic [9:0]  r_rows;
    logic [9:0]  r_cols;
    logic [23:0] r_inv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsize <= RST_FILTER_SIZE;
            r_step  <= RST_SAMPLE_STEP;
            r_rows  <= RST_IMAGE_ROWS;
            r_cols  <= RST_IMAGE_COLS;
            r_inv   <= RST_INV_AREA;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FILTER_SIZE: r_fsize <= i_cfg_wdata[7:0];
                CFG_SAMPLE_STEP: r_step  <= i_cfg_wdata[4:0];
                CFG_IMAGE_ROWS:  r_rows  <= i_cfg_wdata[9:0];
                CFG_IMAGE_COLS:  r_cols  <= i_cfg_wdata[9:0];
                CFG_INV_AREA:    r_inv   <= i_cfg_wdata[23:0];
                default: ;
            endcase
        end
    end

    // integral store
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] r_s2_addr;
    logic [VAL_W-1:0] ram_rdata;

    assign wr_en   = i_cmd.accept && (i_in_data.kind != KIND_QUERY)
                     && (int'(i_in_data.row) < MAX_ROWS) && (int'(i_in_data.col) < MAX_COLS);
    assign wr_addr = {AWR'(i_in_data.row), AWC'(i_in_data.col)};

    bhr_ram #(
        .WIDTH(VAL_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (wr_en),
        .i_waddr(wr_addr),
        .i_wdata(i_in_data.integral_value),
        .i_raddr(r_s2_addr),
        .o_rdata(ram_rdata)
    );

    // query setup
    logic [8:0]  r_qrow, r_qcol;
    logic [13:0] r_r, r_c;
    logic [6:0]  r_l, r_b;
    logic [15:0] div3;

    assign div3 = 16'(r_fsize) * 16'(DIV3_MUL);

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_qrow <= i_in_data.row;
            r_qcol <= i_in_data.col;
        end
        if (i_cmd.setup) begin
            r_r <= 14'(r_qrow) * 14'(r_step);
            r_c <= 14'(r_qcol) * 14'(r_step);
            r_l <= div3[15:9];
            r_b <= (r_fsize == 8'd0) ? 7'd0 : 7'((r_fsize - 8'd1) >> 1);
        end
    end

    // stage 1: corner coordinates
    logic signed [SW-1:0] sl, sl2, sb, sw, shw;
    logic signed [SW-1:0] oy, hh, ox, vv, y1, x1;
    logic [2:0] box;
    logic [1:0] crn;

    assign sl  = signed'(SW'(r_l));
    assign sl2 = signed'(SW'(r_l >> 1));
    assign sb  = signed'(SW'(r_b));
    assign sw  = signed'(SW'(r_fsize));
    assign shw = sl + sl - ONE;
    assign box = i_cmd.idx[4:2];
    assign crn = i_cmd.idx[1:0];

    always_comb begin
        case (box)
            3'd0: begin
                oy = ONE - sl; hh = shw; ox = -sb;       vv = sw;
            end
            3'd1: begin
                oy = ONE - sl; hh = shw; ox = -sl2;      vv = sl;
            end
            3'd2: begin
                oy = -sb;      hh = sw;  ox = ONE - sl;  vv = shw;
            end
            3'd3: begin
                oy = -sl2;     hh = sl;  ox = ONE - sl;  vv = shw;
            end
            3'd4: begin
                oy = -sl;      hh = sl;  ox = ONE;       vv = sl;
            end
            3'd5: begin
                oy = ONE;      hh = sl;  ox = -sl;       vv = sl;
            end
            3'd6: begin
                oy = -sl;      hh = sl;  ox = -sl;       vv = sl;
            end
            default: begin
                oy = ONE;      hh = sl;  ox = ONE;       vv = sl;
            end
        endcase
        y1 = signed'(SW'(r_r)) + oy + (crn[1] ? hh : '0);
        x1 = signed'(SW'(r_c)) + ox + (crn[0] ? vv : '0);
    end

    logic                 r_s1_valid, r_s2_valid, r_s3_valid, r_s4_valid;
    logic signed [SW-1:0] r_s1_y, r_s1_x;
    logic [4:0]           r_s1_tag, r_s2_tag, r_s3_tag;
    logic                 r_s2_zero, r_s3_zero;
    logic [2:0]           r_s4_box;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_cmd.issue;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid && (r_s3_tag[1:0] == 2'd3);
        end
    end

    // stage 2: clamp to image, form address
    logic signed [SW-1:0] nr, nc, rows_s, cols_s, maxr, maxc, ry, rx;

    assign rows_s = signed'(SW'(r_rows));
    assign cols_s = signed'(SW'(r_cols));
    assign maxr   = SW'(MAX_ROWS);
    assign maxc   = SW'(MAX_COLS);
    assign nr     = (rows_s > maxr) ? maxr : rows_s;
    assign nc     = (cols_s > maxc) ? maxc : cols_s;
    assign ry     = ((r_s1_y < nr) ? r_s1_y : nr) - ONE;
    assign rx     = ((r_s1_x < nc) ? r_s1_x : nc) - ONE;

    always_ff @(posedge i_clk) begin
        r_s1_y    <= y1;
        r_s1_x    <= x1;
        r_s1_tag  <= i_cmd.idx;
        r_s2_addr <= {ry[AWR-1:0], rx[AWC-1:0]};
        r_s2_zero <= ry[SW-1] | rx[SW-1];
        r_s2_tag  <= r_s1_tag;
        r_s3_zero <= r_s2_zero;
        r_s3_tag  <= r_s2_tag;
    end

    // stage 3: corner accumulation
    logic signed [BW-1:0] cv, r_acc, bsum, r_s4_val;

    assign cv   = r_s3_zero ? '0 : signed'(BW'(ram_rdata));
    assign bsum = r_acc + cv;

    always_ff @(posedge i_clk) begin
        if (r_s3_valid) begin
            case (r_s3_tag[1:0])
                2'd0:    r_acc <= cv;
                2'd3:    begin
                    r_s4_val <= bsum[BW-1] ? '0 : bsum;
                    r_s4_box <= r_s3_tag[4:2];
                end
                default: r_acc <= r_acc - cv;
            endcase
        end
    end

    // stage 4: derivative accumulation
    logic signed [31:0] r_dxx, r_dyy, r_dxy, dv, dv3;

    assign dv  = 32'(r_s4_val);
    assign dv3 = dv + (dv <<< 1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_dxx <= '0;
            r_dyy <= '0;
            r_dxy <= '0;
        end else if (r_s4_valid) begin
            case (r_s4_box)
                3'd0:    r_dxx <= r_dxx + dv;
                3'd1:    r_dxx <= r_dxx - dv3;
                3'd2:    r_dyy <= r_dyy + dv;
                3'd3:    r_dyy <= r_dyy - dv3;
                3'd4:    r_dxy <= r_dxy + dv;
                3'd5:    r_dxy <= r_dxy + dv;
                default: r_dxy <= r_dxy - dv;
            endcase
        end
    end

    // shared multiplier
    logic signed [32:0] ma, mb;
    logic signed [65:0] mprod;
    logic signed [63:0] r_prod;
    logic               r_prod_valid;
    t_op                r_prod_op;
    logic signed [31:0] r_nxx, r_nyy, r_nxy;
    logic signed [47:0] r_p, r_q, r_wt;
    logic [40:0]        r_wlo, r_whi;

    always_comb begin
        case (i_cmd.op)
            OP_NXX: begin
                ma = 33'(r_dxx); mb = signed'(33'(r_inv));
            end
            OP_NYY: begin
                ma = 33'(r_dyy); mb = signed'(33'(r_inv));
            end
            OP_NXY: begin
                ma = 33'(r_dxy); mb = signed'(33'(r_inv));
            end
            OP_P: begin
                ma = 33'(r_nxx); mb = 33'(r_nyy);
            end
            OP_Q: begin
                ma = 33'(r_nxy); mb = 33'(r_nxy);
            end
            OP_WL: begin
                ma = signed'(33'(r_q[23:0])); mb = signed'(33'(COEF_081));
            end
            OP_WH: begin
                ma = signed'(33'(r_q[47:24])); mb = signed'(33'(COEF_081));
            end
            default: begin
                ma = '0; mb = '0;
            end
        endcase
    end

    assign mprod = ma * mb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_valid <= 1'b0;
        end else begin
            r_prod_valid <= i_cmd.op_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod    <= mprod[63:0];
        r_prod_op <= i_cmd.op;
    end

    // writeback of multiplier results
    logic signed [63:0] sh8, sh16;
    logic signed [31:0] nsat;

    assign sh8  = (r_prod + 64'sd128) >>> 8;
    assign sh16 = (r_prod + 64'sd32768) >>> 16;

    always_comb begin
        if (sh8 > 64'sd2147483647) begin
            nsat = 32'sh7FFFFFFF;
        end else if (sh8 < -64'sd2147483648) begin
            nsat = 32'sh80000000;
        end else begin
            nsat = sh8[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_prod_valid) begin
            case (r_prod_op)
                OP_NXX:  r_nxx <= nsat;
                OP_NYY:  r_nyy <= nsat;
                OP_NXY:  r_nxy <= nsat;
                OP_P:    r_p   <= sh16[47:0];
                OP_Q:    r_q   <= sh16[47:0];
                OP_WL:   r_wlo <= r_prod[40:0];
                OP_WH:   r_whi <= r_prod[40:0];
                default: ;
            endcase
        end
    end

    // weight, laplacian, response
    logic signed [63:0] wfull;
    logic signed [32:0] lsum;
    logic signed [48:0] diff;
    logic signed [39:0] rsat;
    logic signed [39:0] r_resp;
    logic               r_lap;

    assign wfull = (signed'(64'(r_whi)) <<< 24) + signed'(64'(r_wlo)) + 64'sd32768;
    assign lsum  = 33'(r_nxx) + 33'(r_nyy);
    assign diff  = 49'(r_p) - 49'(r_wt);

    always_comb begin
        if (diff > 49'sh007FFFFFFFFF) begin
            rsat = 40'sh7FFFFFFFFF;
        end else if (diff < -49'sh008000000000) begin
            rsat = 40'sh8000000000;
        end else begin
            rsat = diff[39:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc_wt) begin
            r_wt  <= wfull[63:16];
            r_lap <= !lsum[32];
        end
        if (i_cmd.calc_resp) begin
            r_resp <= rsat;
        end
    end

    // output register
    logic      r_out_valid;
    t_out_item r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data.response       <= r_resp;
            r_out_data.laplacian_sign <= r_lap;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_data      = r_out_data;
    assign o_sts.pipe_busy = r_s1_valid | r_s2_valid | r_s3_valid | r_s4_valid;
    assign o_sts.out_free  = !r_out_valid || !i_out_stall;

`ifndef NO_ASSERTIONS
    a_box_from_last_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s4_valid |-> $past(r_s3_valid && r_s3_tag[1:0] == 2'd3))
        else $error("box sum without its last corner");
    a_prod_from_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_prod_valid |-> $past(i_cmd.op_valid))
        else $error("product without issued operation");
    a_setup_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.setup |=> (r_dxx == 32'sd0 && r_dyy == 32'sd0 && r_dxy == 32'sd0))
        else $error("derivative accumulators not cleared");
`endif

endmodule

[hdl/box_hessian_response_core.sv]
// box_hessian_response_core: top level of the box filter hessian response block
// depends on bhr_pkg, bhr_ctrl, bhr_datapath, bhr_ram
//
// channel   direction  handshake                    payload
// input     in         i_in_valid / o_in_stall      i_in_data  (t_in_item)
// output    out        o_out_valid / i_out_stall    o_out_data (t_out_item)
// config    in         i_cfg_we                     i_cfg_index, i_cfg_wdata
//
// a load is written to the integral store on transfer; the time a query takes from
// transfer to result is set by 32 corner reads through the single read port of the integral store
// and seven passes through the one shared multiplier
// reset is synchronous, active low; the integral store is not cleared
// a result waiting in the output register does not block the next transfer in
module box_hessian_response_core #(
    parameter int MAX_ROWS = bhr_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = bhr_pkg::DEF_MAX_COLS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  bhr_pkg::t_in_item         i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output bhr_pkg::t_out_item        o_out_data,
    input  logic                      i_cfg_we,
    input  logic [bhr_pkg::IDX_W-1:0] i_cfg_index,
    input  logic [bhr_pkg::CFG_W-1:0] i_cfg_wdata
);
    import bhr_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    bhr_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .i_in_kind (i_in_data.kind),
        .o_in_stall(o_in_stall),
        .o_cmd     (cmd),
        .i_sts     (sts)
    );

    bhr_datapath #(
        .MAX_ROWS(MAX_ROWS),
        .MAX_COLS(MAX_COLS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_wdata(i_cfg_wdata),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

endmodule

[tb/box_hessian_response_core_tb.sv]
`timescale 1ns / 1ps
// box_hessian_response_core_tb: self-checking testbench of the box hessian response core
// predicts every query result from its own copy of the integral image and registers
// depends on bhr_pkg and box_hessian_response_core
module box_hessian_response_core_tb;
    import bhr_pkg::*;

    localparam int NR = DEF_MAX_ROWS;
    localparam int NC = DEF_MAX_COLS;
    localparam longint CYCLE_LIMIT = 2000000;
    localparam int DRAIN_WAIT = 80;
    localparam int HOLD_CYCLES = 500;
    localparam logic KIND_LOAD = ~KIND_QUERY;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    t_in_item           i_in_data = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    t_out_item          o_out_data;
    logic               i_cfg_we = 1'b0;
    logic [IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_W-1:0]   i_cfg_wdata = '0;

    box_hessian_response_core uut (.*);

    always #5 i_clk = ~i_clk;

    logic [26:0] img_mem [0:NR*NC-1];
    bit          img_loaded [0:NR*NC-1];
    logic [7:0]  fsize = RST_FILTER_SIZE;
    logic [4:0]  sstep = RST_SAMPLE_STEP;
    logic [9:0]  nrows = RST_IMAGE_ROWS;
    logic [9:0]  ncols = RST_IMAGE_COLS;
    logic [23:0] recip_q24 = RST_INV_AREA;

    t_in_item  pending_items[$];
    t_out_item expected_resp[$];
    int        sender_idle_pct = 0;
    int        recv_stall_pct = 0;
    bit        hold_req = 1'b0;
    bit        hold_taken = 1'b0;
    int        hold_left = 0;
    int        errors = 0;
    longint    cycles = 0;

    // in fill mode, queue loads for every in-range corner not yet loaded
    function automatic longint corner_val(longint y, longint x, bit fill);
        t_in_item it;
        int a;
        if (y < 0 || x < 0 || y >= NR || x >= NC) return 0;
        a = int'(y * NC + x);
        if (fill) begin
            if (!img_loaded[a]) begin
                img_loaded[a] = 1'b1;
                it.kind = KIND_LOAD;
                it.row = y[8:0];
                it.col = x[8:0];
                it.integral_value = 27'($urandom);
                pending_items = {pending_items, it};
            end
            return 0;
        end
        return longint'(img_mem[a]);
    endfunction

    function automatic longint box_sum(longint y, longint x, longint h, longint v, bit fill);
        longint rr, cc, r1, c1, r2, c2, s;
        rr = (nrows < NR) ? longint'(nrows) : NR;
        cc = (ncols < NC) ? longint'(ncols) : NC;
        r1 = ((y < rr) ? y : rr) - 1;
        c1 = ((x < cc) ? x : cc) - 1;
        r2 = ((y + h < rr) ? y + h : rr) - 1;
        c2 = ((x + v < cc) ? x + v : cc) - 1;
        s = corner_val(r1, c1, fill) - corner_val(r1, c2, fill)
            - corner_val(r2, c1, fill) + corner_val(r2, c2, fill);
        return (s > 0) ? s : 0;
    endfunction

    function automatic longint norm_q16(longint d);
        longint n;
        n = (d * longint'(recip_q24) + 128) >>> 8;
        if (n > 64'sd2147483647) n = 64'sd2147483647;
        if (n < -64'sd2147483648) n = -64'sd2147483648;
        return n;
    endfunction

    function automatic t_out_item hessian_response(logic [8:0] qrow, logic [8:0] qcol, bit fill);
        t_out_item res;
        longint w, b, l, r, c, dxx, dyy, dxy, p, q, wt, rsp;
        w = longint'(fsize);
        b = (w > 0) ? (w - 1) / 2 : 0;
        l = w / 3;
        r = longint'(qrow) * longint'(sstep);
        c = longint'(qcol) * longint'(sstep);
        dxx = box_sum(r - l + 1, c - b, 2 * l - 1, w, fill)
            - 3 * box_sum(r - l + 1, c - l / 2, 2 * l - 1, l, fill);
        dyy = box_sum(r - b, c - l + 1, w, 2 * l - 1, fill)
            - 3 * box_sum(r - l / 2, c - l + 1, l, 2 * l - 1, fill);
        dxy = box_sum(r - l, c + 1, l, l, fill) + box_sum(r + 1, c - l, l, l, fill)
            - box_sum(r - l, c - l, l, l, fill) - box_sum(r + 1, c + 1, l, l, fill);
        dxx = norm_q16(dxx);
        dyy = norm_q16(dyy);
        dxy = norm_q16(dxy);
        p = (dxx * dyy + 32768) >>> 16;
        q = (dxy * dxy + 32768) >>> 16;
        wt = (q * longint'(COEF_081) + 32768) >>> 16;
        rsp = p - wt;
        if (rsp > 64'sd549755813887) rsp = 64'sd549755813887;
        if (rsp < -64'sd549755813888) rsp = -64'sd549755813888;
        res.response = rsp[39:0];
        res.laplacian_sign = (dxx + dyy >= 0);
        return res;
    endfunction

    function automatic void add_load(logic [8:0] r, logic [8:0] c, logic [26:0] v);
        t_in_item it;
        it.kind = KIND_LOAD;
        it.row = r;
        it.col = c;
        it.integral_value = v;
        img_loaded[int'(r) * NC + int'(c)] = 1'b1;
        pending_items = {pending_items, it};
    endfunction

    function automatic void add_query(logic [8:0] r, logic [8:0] c);
        t_in_item it;
        void'(hessian_response(r, c, 1'b1));
        it.kind = KIND_QUERY;
        it.row = r;
        it.col = c;
        it.integral_value = 27'($urandom);
        pending_items = {pending_items, it};
    endfunction

    function automatic void apply_transfer(t_in_item it);
        if (it.kind == KIND_QUERY)
            expected_resp = {expected_resp, hessian_response(it.row, it.col, 1'b0)};
        else
            img_mem[int'(it.row) * NC + int'(it.col)] = it.integral_value;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) apply_transfer(i_in_data);
            if (!i_in_valid || !o_in_stall) begin
                if (pending_items.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_in_data <= pending_items.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and receiver stall
    always @(posedge i_clk) begin
        t_out_item exp_item;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_resp.size() == 0) begin
                $error("unexpected result transfer: response %0d", o_out_data.response);
                errors++;
            end else begin
                exp_item = expected_resp.pop_front();
                if (o_out_data.response !== exp_item.response) begin
                    $error("response: expected %0d, got %0d",
                           exp_item.response, o_out_data.response);
                    errors++;
                end
                if (o_out_data.laplacian_sign !== exp_item.laplacian_sign) begin
                    $error("laplacian_sign: expected %0d, got %0d",
                           exp_item.laplacian_sign, o_out_data.laplacian_sign);
                    errors++;
                end
            end
        end
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_items.size() != 0 || i_in_valid || expected_resp.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_regs(logic [7:0] fs, logic [4:0] st, logic [9:0] nr,
                              logic [9:0] nc, logic [23:0] ia);
        logic [CFG_W-1:0] vals [5];
        logic [IDX_W-1:0] idxs [5];
        vals = '{CFG_W'(fs), CFG_W'(st), CFG_W'(nr), CFG_W'(nc), ia};
        idxs = '{CFG_FILTER_SIZE, CFG_SAMPLE_STEP, CFG_IMAGE_ROWS, CFG_IMAGE_COLS,
                 CFG_INV_AREA};
        for (int i = 0; i < 5; i++) begin
            @(posedge i_clk);
            i_cfg_we <= 1'b1;
            i_cfg_index <= idxs[i];
            i_cfg_wdata <= vals[i];
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        fsize = fs;
        sstep = st;
        nrows = nr;
        ncols = nc;
        recip_q24 = ia;
    endtask

    function automatic void random_items(int budget);
        int lim_r, lim_c, start;
        logic [8:0] r, c;
        lim_r = (nrows < NR) ? int'(nrows) : NR;
        lim_c = (ncols < NC) ? int'(ncols) : NC;
        if (lim_r < 1) lim_r = 1;
        if (lim_c < 1) lim_c = 1;
        start = pending_items.size();
        while (pending_items.size() - start < budget) begin
            if ($urandom_range(99) < 40) begin
                if ($urandom_range(3) == 0) begin
                    r = 9'($urandom_range(511));
                    c = 9'($urandom_range(511));
                end else begin
                    r = 9'($urandom_range(lim_r - 1));
                    c = 9'($urandom_range(lim_c - 1));
                end
                add_load(r, c, 27'($urandom));
            end else if ($urandom_range(3) == 0) begin
                add_query(9'($urandom_range(511)), 9'($urandom_range(511)));
            end else begin
                r = 9'($urandom_range((lim_r - 1) / (sstep == 0 ? 1 : int'(sstep))));
                c = 9'($urandom_range((lim_c - 1) / (sstep == 0 ? 1 : int'(sstep))));
                add_query(r, c);
            end
        end
    endfunction

    initial begin
        logic [7:0]  cf_fs [8];
        logic [4:0]  cf_st [8];
        logic [9:0]  cf_nr [8];
        logic [9:0]  cf_nc [8];
        logic [23:0] cf_ia [8];
        int pct_idle [4];
        int pct_stall [4];
        cf_fs = '{9, 15, 255, 9, 27, 51, 9, 255};
        cf_st = '{1, 2, 16, 1, 3, 5, 16, 1};
        cf_nr = '{512, 64, 512, 1, 100, 512, 512, 1};
        cf_nc = '{512, 64, 512, 1, 37, 200, 512, 512};
        cf_ia = '{207126, 74565, 16777215, 0, 23014, 6450, 16777215, 258};
        pct_idle = '{0, 62, 0, 17};
        pct_stall = '{0, 0, 62, 17};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes and boundary queries under reset settings
        add_load(9'd0, 9'd0, 27'd0);
        add_load(9'd511, 9'd511, 27'h7FFFFFF);
        add_load(9'd0, 9'd511, 27'h7FFFFFF);
        add_load(9'd511, 9'd0, 27'h5555555);
        add_load(9'd10, 9'd10, 27'h2AAAAAA);
        add_query(9'd0, 9'd0);
        add_query(9'd511, 9'd511);
        add_query(9'd0, 9'd511);
        add_query(9'd511, 9'd0);
        add_query(9'd10, 9'd10);
        add_query(9'd255, 9'd256);
        add_query(9'd4, 9'd4);
        wait_drained();

        for (int ph = 0; ph < 8; ph++) begin
            write_regs(cf_fs[ph], cf_st[ph], cf_nr[ph], cf_nc[ph], cf_ia[ph]);
            @(posedge i_clk);
            sender_idle_pct <= pct_idle[ph % 4];
            recv_stall_pct <= pct_stall[ph % 4];
            if (ph == 1) hold_req <= 1'b1;
            if (ph == 3) begin
                add_query(9'd0, 9'd0);
                add_query(9'd511, 9'd511);
            end
            random_items(55);
            // queue nothing more until every item is sent and every result is back
            wait_drained();
            random_items(55);
            wait_drained();
        end

        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

[sim.f]
hdl/bhr_pkg.sv
hdl/bhr_ram.sv
hdl/bhr_ctrl.sv
hdl/bhr_datapath.sv
hdl/box_hessian_response_core.sv
tb/box_hessian_response_core_tb.sv
